// ----- rtl/core/mcls_pkg.sv -----
// shared types and constants of the match context line selector
`timescale 1ns / 1ps

package mcls_pkg;

  // default sizes handed to the top level parameters
  localparam int BEFORE_DEPTH_DEF = 16;
  localparam int LINE_BITS_DEF    = 32;

  // configuration port
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;
  localparam int CFG_BEFORE_W = 5;
  localparam int CFG_AFTER_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BEFORE_LINES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AFTER_LINES  = 1'd1;

  // stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_LINE_W  = 32;
  localparam int TOTAL_W     = 32;
  localparam int OUT_TDATA_W = OUT_LINE_W + TOTAL_W;

  // command queue between front and back, power of two
  localparam int QUEUE_DEPTH = 4;

  // kind of result transaction
  typedef enum logic [1:0] {
    EMIT_SEP    = 2'd0,
    EMIT_BEFORE = 2'd1,
    EMIT_MATCH  = 2'd2,
    EMIT_AFTER  = 2'd3
  } emit_kind_e;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_AFTER = 2'd1,
    CMD_MATCH = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    cmd_kind_e          kind;
  } cmd_ctl_t;

endpackage

// ----- rtl/core/mcls_front.sv -----
// front end: takes line events, counts lines and matches, classifies into commands
`timescale 1ns / 1ps

module mcls_front #(
  parameter int LINE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [mcls_pkg::CFG_BEFORE_W-1:0]  before_lines_i,
  input  logic [mcls_pkg::CFG_AFTER_W-1:0]   after_lines_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               line_matched_i,
  input  logic                               line_filtered_i,
  output logic                               q_push_o,
  output logic [LINE_BITS-1:0]               q_line_o,
  output mcls_pkg::cmd_ctl_t                 q_ctl_o,
  input  logic                               q_full_i
);
  import mcls_pkg::*;

  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [TOTAL_W-1:0]     match_q, match_d;
  logic [CFG_AFTER_W-1:0] after_rem_q, after_rem_d;
  logic                   accept;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // counters and classification of one line
  always_comb begin
    line_d        = line_q;
    match_d       = match_q;
    after_rem_d   = after_rem_q;
    q_push_o      = 1'b0;
    q_ctl_o.kind  = CMD_PUSH;
    q_ctl_o.total = match_q;
    if (accept) begin
      if (!(&line_q)) begin
        line_d = line_q + 1'b1;
      end
      if (!line_filtered_i) begin
        if (line_matched_i) begin
          if (!(&match_q)) begin
            match_d = match_q + 1'b1;
          end
          after_rem_d   = after_lines_i;
          q_push_o      = 1'b1;
          q_ctl_o.kind  = CMD_MATCH;
          q_ctl_o.total = match_d;
        end else if (after_rem_q != '0) begin
          after_rem_d  = after_rem_q - 1'b1;
          q_push_o     = 1'b1;
          q_ctl_o.kind = CMD_AFTER;
        end else if (before_lines_i != '0) begin
          q_push_o     = 1'b1;
          q_ctl_o.kind = CMD_PUSH;
        end
      end
    end
  end

  assign q_line_o = line_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      match_q     <= '0;
      after_rem_q <= '0;
    end else begin
      line_q      <= line_d;
      match_q     <= match_d;
      after_rem_q <= after_rem_d;
    end
  end

endmodule

// ----- rtl/core/mcls_cmd_fifo.sv -----
// small command queue between the front and back ends
`timescale 1ns / 1ps

module mcls_cmd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             pop_i
);
  import mcls_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/core/mcls_back.sv -----
// back end: owns the before-context ring and produces result transactions
`timescale 1ns / 1ps

module mcls_back #(
  parameter int BEFORE_DEPTH = 16,
  parameter int LINE_BITS    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mcls_pkg::CFG_BEFORE_W-1:0]   before_lines_i,
  input  logic                                q_valid_i,
  input  logic [LINE_BITS-1:0]                q_line_i,
  input  mcls_pkg::cmd_ctl_t                  q_ctl_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          out_kind_o,
  output logic [mcls_pkg::OUT_LINE_W-1:0]     out_line_o,
  output logic [mcls_pkg::TOTAL_W-1:0]        out_total_o,
  output logic                                out_last_o
);
  import mcls_pkg::*;

  localparam int IW = (BEFORE_DEPTH > 1) ? $clog2(BEFORE_DEPTH) : 1;
  localparam int FW = $clog2(BEFORE_DEPTH + 1);
  localparam int CW = (FW > CFG_BEFORE_W) ? FW : CFG_BEFORE_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SEP   = 5'b00010,
    S_RD    = 5'b00100,
    S_CMP   = 5'b01000,
    S_MATCH = 5'b10000
  } state_e;

  // index into the ring from a sum below twice the depth
  function automatic logic [IW-1:0] ring_wrap(input logic [FW:0] sum);
    logic [FW:0] r;
    r = (sum >= (FW+1)'(BEFORE_DEPTH)) ? sum - (FW+1)'(BEFORE_DEPTH) : sum;
    return r[IW-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [LINE_BITS-1:0] last_q, last_d;
  logic                 printed_q, printed_d;
  logic [IW-1:0]        head_q, head_d;
  logic [FW-1:0]        fill_q, fill_d;
  logic [FW-1:0]        idx_q, idx_d;
  logic [LINE_BITS-1:0] cur_line_q, cur_line_d;
  logic [TOTAL_W-1:0]   cur_total_q, cur_total_d;

  logic [LINE_BITS-1:0] ring_mem [BEFORE_DEPTH];
  logic [LINE_BITS-1:0] rd_q;
  logic                 ring_we;
  logic [IW-1:0]        ring_wa, ring_ra;

  logic                 slot_free;
  logic                 emit;
  emit_kind_e           emit_kind;
  logic [LINE_BITS-1:0] emit_num;
  logic [TOTAL_W-1:0]   emit_total;
  logic                 emit_last;
  logic [CW-1:0]        depth_w;
  logic [FW-1:0]        depth;
  logic [FW:0]          idx_next;
  logic [LINE_BITS+OUT_LINE_W-1:0] num_ext;

  assign slot_free = ~out_valid_o | out_ready_i;

  // effective ring depth, capped at the storage size
  assign depth_w = (CW'(before_lines_i) > CW'(BEFORE_DEPTH)) ? CW'(BEFORE_DEPTH)
                                                             : CW'(before_lines_i);
  assign depth    = depth_w[FW-1:0];
  assign idx_next = (FW+1)'(idx_q) + 1'b1;

  // sequencer
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    printed_d   = printed_q;
    head_d      = head_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    cur_line_d  = cur_line_q;
    cur_total_d = cur_total_q;
    q_pop_o     = 1'b0;
    ring_we     = 1'b0;
    ring_wa     = head_q;
    ring_ra     = ring_wrap((FW+1)'(head_q) + (FW+1)'(idx_q));
    emit        = 1'b0;
    emit_kind   = EMIT_SEP;
    emit_num    = '0;
    emit_total  = cur_total_q;
    emit_last   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_ctl_i.kind)
            CMD_PUSH: begin
              q_pop_o = 1'b1;
              ring_we = 1'b1;
              if (fill_q < FW'(BEFORE_DEPTH)) begin
                ring_wa = ring_wrap((FW+1)'(head_q) + (FW+1)'(fill_q));
                if (((FW+1)'(fill_q) + 1'b1) > (FW+1)'(depth)) begin
                  head_d = ring_wrap((FW+1)'(head_q) + 1'b1);
                end else begin
                  fill_d = fill_q + 1'b1;
                end
              end else begin
                ring_wa = head_q;
                head_d  = ring_wrap((FW+1)'(head_q) + 1'b1);
              end
            end
            CMD_AFTER: begin
              if (slot_free) begin
                q_pop_o = 1'b1;
                if (q_line_i > last_q) begin
                  emit       = 1'b1;
                  emit_kind  = EMIT_AFTER;
                  emit_num   = q_line_i;
                  emit_total = q_ctl_i.total;
                  emit_last  = 1'b1;
                  last_d     = q_line_i;
                end
              end
            end
            CMD_MATCH: begin
              q_pop_o     = 1'b1;
              cur_line_d  = q_line_i;
              cur_total_d = q_ctl_i.total;
              idx_d       = '0;
              state_d     = S_SEP;
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      S_SEP: begin
        if (printed_q && cur_line_q > last_q &&
            (cur_line_q - last_q) > LINE_BITS'(1)) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_kind = EMIT_SEP;
            state_d   = (fill_q != '0) ? S_RD : S_MATCH;
          end
        end else begin
          state_d = (fill_q != '0) ? S_RD : S_MATCH;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rd_q > last_q) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_kind = EMIT_BEFORE;
            emit_num  = rd_q;
            last_d    = rd_q;
            idx_d     = idx_next[FW-1:0];
            state_d   = (idx_next < (FW+1)'(fill_q)) ? S_RD : S_MATCH;
          end
        end else begin
          idx_d   = idx_next[FW-1:0];
          state_d = (idx_next < (FW+1)'(fill_q)) ? S_RD : S_MATCH;
        end
      end
      S_MATCH: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = EMIT_MATCH;
          emit_num  = cur_line_q;
          emit_last = 1'b1;
          last_d    = cur_line_q;
          printed_d = 1'b1;
          head_d    = '0;
          fill_d    = '0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      last_q    <= '0;
      printed_q <= 1'b0;
      head_q    <= '0;
      fill_q    <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      printed_q <= printed_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_line_q  <= cur_line_d;
    cur_total_q <= cur_total_d;
  end

  // before-context ring, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= q_line_i;
    end
    rd_q <= ring_mem[ring_ra];
  end

  // output register
  assign num_ext = {{OUT_LINE_W{1'b0}}, emit_num};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_o  <= emit_kind;
      out_line_o  <= num_ext[OUT_LINE_W-1:0];
      out_total_o <= emit_total;
      out_last_o  <= emit_last;
    end
  end

endmodule

// ----- rtl/core/match_context_line_selector_top.sv -----
// top level of the match context line selector
`timescale 1ns / 1ps

// Takes one event per text line on the slave stream and returns the numbers of
// the lines to print on the master stream, grep style: a separator before a
// match that is more than one line past the last printed one, the buffered
// before-context lines, the match, then up to after_lines following lines.
// The front end takes one line event per cycle while its four-entry command
// queue has room. The back end stores a before-context line or prints an
// after-context line straight from its idle state; on a match it takes the
// command, passes the separator step, then for each buffered line does a
// registered ring read and then a compare and output, and last outputs the
// match. Results wait in a single output register; while the downstream side
// stalls, the back end still buffers lines and steps through states that emit
// nothing, but waits to emit a result. The ring of BEFORE_DEPTH entries needs
// no clearing after reset; only filled entries are read.
module match_context_line_selector_top #(
  parameter int BEFORE_DEPTH = mcls_pkg::BEFORE_DEPTH_DEF,
  parameter int LINE_BITS    = mcls_pkg::LINE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mcls_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mcls_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] line_matched, rest zero
  input  logic [mcls_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] line_filtered
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] line_number, [63:32] match_total
  output logic [mcls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] emit_kind
  output logic [1:0]                         m_axis_tuser,
  // last_of_run
  output logic                               m_axis_tlast
);
  import mcls_pkg::*;

  localparam int QW = LINE_BITS + $bits(cmd_ctl_t);

  logic [CFG_BEFORE_W-1:0] before_lines_q;
  logic [CFG_AFTER_W-1:0]  after_lines_q;

  logic                 f_push, f_full;
  logic [LINE_BITS-1:0] f_line;
  cmd_ctl_t             f_ctl;
  logic                 b_valid, b_pop;
  logic [QW-1:0]        b_rdata;
  logic [OUT_LINE_W-1:0] out_line;
  logic [TOTAL_W-1:0]   out_total;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_lines_q <= '0;
      after_lines_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BEFORE_LINES: before_lines_q <= cfg_wdata_i[CFG_BEFORE_W-1:0];
        CFG_AFTER_LINES:  after_lines_q  <= cfg_wdata_i[CFG_AFTER_W-1:0];
        default: ;
      endcase
    end
  end

  mcls_front #(
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .before_lines_i  (before_lines_q),
    .after_lines_i   (after_lines_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .line_matched_i  (s_axis_tdata[0]),
    .line_filtered_i (s_axis_tuser),
    .q_push_o        (f_push),
    .q_line_o        (f_line),
    .q_ctl_o         (f_ctl),
    .q_full_i        (f_full)
  );

  mcls_cmd_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i ({f_line, f_ctl}),
    .full_o  (f_full),
    .valid_o (b_valid),
    .rdata_o (b_rdata),
    .pop_i   (b_pop)
  );

  mcls_back #(
    .BEFORE_DEPTH (BEFORE_DEPTH),
    .LINE_BITS    (LINE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .before_lines_i (before_lines_q),
    .q_valid_i      (b_valid),
    .q_line_i       (b_rdata[QW-1 -: LINE_BITS]),
    .q_ctl_i        (cmd_ctl_t'(b_rdata[$bits(cmd_ctl_t)-1:0])),
    .q_pop_o        (b_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_kind_o     (m_axis_tuser),
    .out_line_o     (out_line),
    .out_total_o    (out_total),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {out_total, out_line};

endmodule

// ----- rtl/core/mcls_checker.sv -----
// port-level checks of the match context line selector, bound to the top level
`timescale 1ns / 1ps

module mcls_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mcls_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                       m_axis_tuser,
  input logic                             m_axis_tlast
);
  import mcls_pkg::*;

  // a stalled result transaction keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a match or an after-context line closes the run of its line
  a_match_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EMIT_MATCH || m_axis_tuser == EMIT_AFTER)
      |-> m_axis_tlast)
    else $error("match or after context without last flag");

  // separator and before context precede the match, so they are never marked last
  a_lead_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EMIT_SEP || m_axis_tuser == EMIT_BEFORE)
      |-> !m_axis_tlast)
    else $error("separator or before context marked last");

  // a separator carries line number zero
  a_sep_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EMIT_SEP |-> m_axis_tdata[OUT_LINE_W-1:0] == '0)
    else $error("separator with nonzero line number");

endmodule

bind match_context_line_selector_top mcls_checker u_mcls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
